@@ rtl/eiau_pkg.sv @@
// Shared types, codes and helpers of the elementwise integer arithmetic unit.
package eiau_pkg;

  localparam int DATA_W = 64;
  localparam int HALF_W = DATA_W / 2;
  localparam int OP_W   = 3;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_WIDTH = 2'd1;

  // Control and payload travelling beside the divider
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              wide;
    logic              last;
    logic              neg_a;
    logic              neg_b;
    logic              b_zero;
    logic              b_m1;
    logic [DATA_W-1:0] res;
  } side_t;

  // Sign-extend from 32 bits in narrow mode
  function automatic logic [DATA_W-1:0] sext_elem(input logic [DATA_W-1:0] v,
                                                  input logic wide);
    return wide ? v : {{(DATA_W-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
  endfunction

  function automatic logic [DATA_W-1:0] abs_val(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ rtl/eiau_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module eiau_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [eiau_pkg::DATA_W-1:0] dvd,
  input  logic [eiau_pkg::DATA_W-1:0] dvs,
  output logic [eiau_pkg::DATA_W-1:0] quo,
  output logic [eiau_pkg::DATA_W-1:0] rem
);

  localparam int W = eiau_pkg::DATA_W;

  logic [W-1:0] rem_r [0:W-1];
  logic [W-1:0] quo_r [0:W-1];
  logic [W-1:0] dvs_r [0:W-1];

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_stage
      logic [W-1:0] rem_in;
      logic [W-1:0] quo_in;
      logic [W-1:0] dvs_in;
      logic [W:0]   diff;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign quo_in = dvd;
        assign dvs_in = dvs;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign quo_in = quo_r[k-1];
        assign dvs_in = dvs_r[k-1];
      end

      assign diff = {rem_in, quo_in[W-1]} - {1'b0, dvs_in};

      always_ff @(posedge clk) begin
        if (en) begin
          dvs_r[k] <= dvs_in;
          if (!diff[W]) begin
            rem_r[k] <= diff[W-1:0];
            quo_r[k] <= {quo_in[W-2:0], 1'b1};
          end else begin
            rem_r[k] <= {rem_in[W-2:0], quo_in[W-1]};
            quo_r[k] <= {quo_in[W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign quo = quo_r[W-1];
  assign rem = rem_r[W-1];

endmodule

@@ rtl/elementwise_integer_arith_unit_top.sv @@
// Top level of the elementwise integer arithmetic unit.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in_     | in        | in_valid / in_stall     | operand_a, operand_b, last_in
//  out_    | out       | out_valid / out_stall   | result_value, last_out
//  cfg_    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One transaction is taken per cycle while the output is not stalled; each result
// passes through s0, s1, the 64-stage divider pipe and the output register, and
// every operation passes through that pipe so results keep their order.
// rst_n (synchronous, active low) clears valid bits and configuration only.
// A stalled output freezes the whole pipe at once; in_stall is raised for
// exactly those cycles, so nothing is dropped or repeated.
module elementwise_integer_arith_unit_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [eiau_pkg::DATA_W-1:0]    in_operand_a,
  input  logic signed [eiau_pkg::DATA_W-1:0]    in_operand_b,
  input  logic                                  in_last_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [eiau_pkg::DATA_W-1:0]    out_result_value,
  output logic                                  out_last_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [eiau_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [eiau_pkg::CFG_DAT_W-1:0]        cfg_data
);

  localparam int W  = eiau_pkg::DATA_W;
  localparam int HW = eiau_pkg::HALF_W;
  localparam int NV = W + 2;   // valid bits from s0 to the divider output

  // ---------------- configuration ----------------
  logic [eiau_pkg::OP_W-1:0] op_r;
  logic                      wide_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= eiau_pkg::OP_ADD;
      wide_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        eiau_pkg::REG_OPERATION:     op_r   <= cfg_data[eiau_pkg::OP_W-1:0];
        eiau_pkg::REG_ELEMENT_WIDTH: wide_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic [NV-1:0] vld_r;
  logic          out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // ---------------- s0: operand capture, sign-extended ----------------
  logic [W-1:0]              a0_r, b0_r;
  logic [eiau_pkg::OP_W-1:0] op0_r;
  logic                      wide0_r, last0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r    <= eiau_pkg::sext_elem(in_operand_a, wide_r);
      b0_r    <= eiau_pkg::sext_elem(in_operand_b, wide_r);
      op0_r   <= op_r;
      wide0_r <= wide_r;
      last0_r <= in_last_in;
    end
  end

  // ---------------- s1: add/sub, partial products, magnitudes ----------------
  logic [W-1:0]              sum1_r, diff1_r, nega1_r, mag_a1_r, mag_b1_r;
  logic [W-1:0]              pp_ll1_r;
  logic [HW-1:0]             pp_lh1_r, pp_hl1_r;
  logic [eiau_pkg::OP_W-1:0] op1_r;
  logic                      wide1_r, last1_r, neg_a1_r, neg_b1_r, bz1_r, bm1_1_r;
  logic [W-1:0]              pp_lh_full, pp_hl_full;

  assign pp_lh_full = a0_r[HW-1:0] * b0_r[W-1:HW];
  assign pp_hl_full = a0_r[W-1:HW] * b0_r[HW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r   <= a0_r + b0_r;
      diff1_r  <= a0_r - b0_r;
      nega1_r  <= ~a0_r + 1'b1;
      mag_a1_r <= eiau_pkg::abs_val(a0_r);
      mag_b1_r <= eiau_pkg::abs_val(b0_r);
      pp_ll1_r <= a0_r[HW-1:0] * b0_r[HW-1:0];
      pp_lh1_r <= pp_lh_full[HW-1:0];
      pp_hl1_r <= pp_hl_full[HW-1:0];
      op1_r    <= op0_r;
      wide1_r  <= wide0_r;
      last1_r  <= last0_r;
      neg_a1_r <= a0_r[W-1];
      neg_b1_r <= b0_r[W-1];
      bz1_r    <= (b0_r == '0);
      bm1_1_r  <= (b0_r == '1);
    end
  end

  // ---------------- s2: product and early result ----------------
  logic [W-1:0]  mul2;
  logic [HW-1:0] cross2;
  eiau_pkg::side_t side2;

  assign cross2 = pp_lh1_r + pp_hl1_r;
  assign mul2   = pp_ll1_r + {cross2, {HW{1'b0}}};

  always_comb begin
    side2.op     = op1_r;
    side2.wide   = wide1_r;
    side2.last   = last1_r;
    side2.neg_a  = neg_a1_r;
    side2.neg_b  = neg_b1_r;
    side2.b_zero = bz1_r;
    side2.b_m1   = bm1_1_r;
    case (op1_r)
      eiau_pkg::OP_ADD: side2.res = sum1_r;
      eiau_pkg::OP_SUB: side2.res = diff1_r;
      eiau_pkg::OP_MUL: side2.res = mul2;
      eiau_pkg::OP_DIV: side2.res = (bm1_1_r && !bz1_r) ? nega1_r : '0;
      default:          side2.res = '0;
    endcase
  end

  // Sideband delay line, aligned with the divider output
  eiau_pkg::side_t side_r [0:W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side2;
      for (int i = 1; i < W; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---------------- divider ----------------
  logic [W-1:0] quo, rem;

  eiau_div u_div (
    .clk (clk),
    .en  (en),
    .dvd (mag_a1_r),
    .dvs (mag_b1_r),
    .quo (quo),
    .rem (rem)
  );

  // ---------------- output stage ----------------
  eiau_pkg::side_t sf;
  logic [W-1:0]    res_f;
  logic            guarded;
  logic [W-1:0]    out_res_r;
  logic            out_last_r;

  assign sf      = side_r[W-1];
  assign guarded = !sf.b_zero && !sf.b_m1;

  always_comb begin
    res_f = sf.res;
    if (sf.op == eiau_pkg::OP_DIV && guarded) begin
      res_f = (sf.neg_a ^ sf.neg_b) ? (~quo + 1'b1) : quo;
    end else if (sf.op == eiau_pkg::OP_MOD) begin
      res_f = !guarded ? '0 : (sf.neg_a ? (~rem + 1'b1) : rem);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r  <= eiau_pkg::sext_elem(res_f, sf.wide);
      out_last_r <= sf.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_last_out     = out_last_r;

  // ---------------- checks ----------------
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[NV-1] && sf.op == eiau_pkg::OP_DIV && sf.b_zero
    |=> out_result_value == '0)
    else $error("divide by zero did not give zero");

  a_mod_m1: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[NV-1] && sf.op == eiau_pkg::OP_MOD && sf.b_m1
    |=> out_result_value == '0)
    else $error("modulo by minus one did not give zero");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && out_valid_r)
    else $error("pipe moved while stalled");

endmodule

@@ verif/tb_elementwise_integer_arith_unit_top.sv @@
// Self-checking testbench for the elementwise integer arithmetic unit top level.
module tb_elementwise_integer_arith_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW        = eiau_pkg::DATA_W;
  localparam int OW        = eiau_pkg::OP_W;
  localparam int N_RANDOM  = 1100;
  localparam int LAT       = eiau_pkg::DATA_W + 3;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] in_operand_a = '0;
  logic signed [DW-1:0] in_operand_b = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_result_value;
  logic out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [eiau_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [eiau_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  elementwise_integer_arith_unit_top dut (.*);

  // One expected output transaction
  typedef struct {
    logic [DW-1:0] value;
    logic          last;
  } res_t;

  // Directed row: set cfg first if set_cfg, then send operands
  typedef struct {
    bit            set_cfg;
    logic [OW-1:0] op;
    bit            wide;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    bit            last;
    bit            typed;
    logic [DW-1:0] want;
  } row_t;

  res_t   result_q[$];
  logic [OW-1:0] cur_op = eiau_pkg::OP_ADD;
  bit     cur_wide = 1'b1;
  int     n_err = 0;
  int     n_seen = 0;
  int     n_sent = 0;
  longint cycles = 0;
  bit     allow_stall = 1'b1;

  localparam logic [DW-1:0] MINW = 64'h8000_0000_0000_0000;
  localparam logic [DW-1:0] MAXW = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DW-1:0] M1   = '1;
  localparam logic [DW-1:0] MIN32 = 64'hFFFF_FFFF_8000_0000;

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [DW-1:0] narrow(input logic [DW-1:0] v, input bit wide);
    return wide ? v : {{32{v[31]}}, v[31:0]};
  endfunction

  // Arithmetic result for the current operation and width
  function automatic logic [DW-1:0] alu_result(input logic [OW-1:0] op, input bit wide,
                                               input logic [DW-1:0] ra,
                                               input logic [DW-1:0] rb);
    logic [DW-1:0] a, b, r, ma, mb, q;
    a = narrow(ra, wide);
    b = narrow(rb, wide);
    ma = a[DW-1] ? -a : a;
    mb = b[DW-1] ? -b : b;
    r = '0;
    case (op)
      eiau_pkg::OP_ADD: r = a + b;
      eiau_pkg::OP_SUB: r = a - b;
      eiau_pkg::OP_MUL: r = a * b;
      eiau_pkg::OP_DIV: begin
        if (b == '0) r = '0;
        else if (b == M1) r = -a;
        else begin
          q = ma / mb;
          r = (a[DW-1] != b[DW-1]) ? -q : q;
        end
      end
      eiau_pkg::OP_MOD: begin
        if (b == '0 || b == M1) r = '0;
        else begin
          q = ma % mb;
          r = a[DW-1] ? -q : q;
        end
      end
      default: r = '0;
    endcase
    return narrow(r, wide);
  endfunction

  // Leaves cfg_valid high; the caller drops it after its last write
  task automatic cfg_write(input logic [eiau_pkg::CFG_IDX_W-1:0] idx,
                           input logic [eiau_pkg::CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == eiau_pkg::REG_OPERATION) cur_op = d[OW-1:0];
    else if (idx == eiau_pkg::REG_ELEMENT_WIDTH) cur_wide = d[0];
  endtask

  // Wait for the pipe to empty before touching configuration
  task automatic drain();
    while (result_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [OW-1:0] op, input bit wide);
    drain();
    cfg_write(eiau_pkg::REG_OPERATION, eiau_pkg::CFG_DAT_W'(op));
    cfg_write(eiau_pkg::REG_ELEMENT_WIDTH, eiau_pkg::CFG_DAT_W'(wide));
    cfg_valid <= 1'b0;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Send one operand pair; expectation queued on acceptance
  task automatic send_pair(input logic [DW-1:0] a, input logic [DW-1:0] b,
                           input bit last, input bit typed, input logic [DW-1:0] want);
    res_t e;
    in_valid     <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    in_last_in   <= last;
    do @(posedge clk); while (in_stall);
    e.value = typed ? want : alu_result(cur_op, cur_wide, a, b);
    e.last  = last;
    result_q.push_back(e);
    n_sent++;
  endtask

  task automatic idle_in(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [DW-1:0] rand_operand(input bit wide);
    logic [DW-1:0] v;
    int p;
    v = {$urandom, $urandom};
    p = $urandom_range(0, 99);
    if (p < 8) v = '0;
    else if (p < 16) v = M1;
    else if (p < 22) v = wide ? MINW : MIN32 | (v & 64'hFFFF_FFFF_0000_0000);
    else if (p < 28) v = wide ? MAXW : 64'h7FFF_FFFF;
    else if (p < 45) v = {{56{v[7]}}, v[7:0]};
    else if (p < 55) v = {v[63:32], {16{v[15]}}, v[15:0]};
    return v;
  endfunction

  // Output side: random stalls, and compare every accepted result
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_seen++;
      if (result_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("Unexpected result %h", out_result_value);
      end else begin
        e = result_q.pop_front();
        if (out_result_value !== e.value || out_last_out !== e.last) begin
          n_err++;
          if (n_err <= 10)
            $display("Mismatch #%0d: value exp %h got %h, last exp %b got %b",
                     n_seen, e.value, out_result_value, e.last, out_last_out);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!allow_stall) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= gap_len();
      out_stall  <= 1'b1;
    end else out_stall <= 1'b0;
  end

  row_t dir_rows[] = '{
    // after reset: 64-bit add
    '{0, eiau_pkg::OP_ADD, 1, MAXW, 64'd1, 0, 1, MINW},
    '{0, eiau_pkg::OP_ADD, 1, M1, M1, 1, 1, 64'hFFFF_FFFF_FFFF_FFFE},
    '{1, eiau_pkg::OP_SUB, 1, MINW, 64'd1, 0, 1, MAXW},
    '{0, eiau_pkg::OP_SUB, 1, 64'd0, MINW, 1, 1, MINW},
    '{1, eiau_pkg::OP_MUL, 1, MAXW, MAXW, 0, 0, 64'd0},
    '{0, eiau_pkg::OP_MUL, 1, MINW, M1, 0, 1, MINW},
    '{1, eiau_pkg::OP_DIV, 1, 64'd7, 64'd0, 0, 1, 64'd0},
    '{0, eiau_pkg::OP_DIV, 1, MINW, M1, 1, 1, MINW},
    '{0, eiau_pkg::OP_DIV, 1, -64'sd7, 64'd2, 0, 1, -64'sd3},
    '{0, eiau_pkg::OP_DIV, 1, 64'd7, -64'sd2, 0, 1, -64'sd3},
    '{1, eiau_pkg::OP_MOD, 1, 64'd7, 64'd0, 0, 1, 64'd0},
    '{0, eiau_pkg::OP_MOD, 1, MINW, M1, 0, 1, 64'd0},
    '{0, eiau_pkg::OP_MOD, 1, -64'sd7, 64'd2, 1, 1, M1},
    '{0, eiau_pkg::OP_MOD, 1, 64'd7, -64'sd2, 0, 1, 64'd1},
    // 32-bit mode: upper operand bits ignored, result sign-extended
    '{1, eiau_pkg::OP_ADD, 0, 64'hDEAD_BEEF_7FFF_FFFF, 64'h1234_5678_0000_0001, 0, 1, MIN32},
    '{1, eiau_pkg::OP_SUB, 0, 64'hAAAA_AAAA_8000_0000, 64'd1, 0, 1, 64'h7FFF_FFFF},
    '{1, eiau_pkg::OP_MUL, 0, 64'h0000_0000_0001_0000, 64'hFFFF_0000_0001_0000, 0, 1, 64'd0},
    '{1, eiau_pkg::OP_DIV, 0, 64'h5555_5555_8000_0000, 64'h0000_0000_FFFF_FFFF, 1, 1, MIN32},
    '{0, eiau_pkg::OP_DIV, 0, 64'd9, 64'hFFFF_FFFF_0000_0000, 0, 1, 64'd0},
    '{1, eiau_pkg::OP_MOD, 0, MIN32, 64'h1234_0000_FFFF_FFFF, 0, 1, 64'd0},
    '{0, eiau_pkg::OP_MOD, 0, 64'hFFFF_FFFF_FFFF_FFF9, 64'd3, 1, 1, M1},
    // unused operation codes give zero
    '{1, 3'd5, 1, MAXW, 64'd3, 1, 1, 64'd0},
    '{1, 3'd6, 0, 64'd5, 64'd3, 0, 1, 64'd0},
    '{1, 3'd7, 1, M1, M1, 1, 1, 64'd0}
  };

  initial begin
    logic [OW-1:0] op;
    bit wide;
    int burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) begin
        idle_in(1);
        set_mode(dir_rows[i].op, dir_rows[i].wide);
      end
      send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].want);
      idle_in(gap_len());
    end

    // Random phases, each with its own mode; some without any gaps at all
    while (n_sent < N_RANDOM + $size(dir_rows)) begin
      op   = ($urandom_range(0, 19) == 0) ? OW'($urandom_range(5, 7))
                                          : OW'($urandom_range(0, 4));
      wide = 1'($urandom_range(0, 1));
      idle_in(1);
      set_mode(op, wide);
      burst = $urandom_range(20, 80);
      allow_stall = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < burst; k++) begin
        send_pair(rand_operand(wide), rand_operand(wide), 1'($urandom_range(0, 1)),
                  1'b0, '0);
        if (allow_stall) idle_in(gap_len());
      end
      allow_stall = 1'b1;
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);

    $display("Sent %0d operand pairs over all five operations, unused codes and both widths;",
             n_sent);
    $display("checked %0d results, %0d mismatches.", n_seen, n_err);
    if (n_err == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
